/* hdl/xts_pkg.sv */
// ----------------------------------------------------------------------------
// xts_pkg: shared types and constants of the XPath token scanner
// Payload structs, token kind codes and sizing constants.
// ----------------------------------------------------------------------------
package xts_pkg;

  localparam int MAX_TEXT    = 4096;
  localparam int POS_W       = 12;
  localparam int LEN_W       = 13;
  localparam int KIND_W      = 5;
  localparam int RES_MAX     = 4;   // results one byte can cause
  localparam int QUEUE_DEPTH = 8;   // power of two, at least RES_MAX

  localparam logic [KIND_W-1:0] K_LPAR       = 5'd0;
  localparam logic [KIND_W-1:0] K_RPAR       = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRAC      = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRAC      = 5'd3;
  localparam logic [KIND_W-1:0] K_DOT        = 5'd4;
  localparam logic [KIND_W-1:0] K_DOTDOT     = 5'd5;
  localparam logic [KIND_W-1:0] K_AT         = 5'd6;
  localparam logic [KIND_W-1:0] K_COMMA      = 5'd7;
  localparam logic [KIND_W-1:0] K_COLON      = 5'd8;
  localparam logic [KIND_W-1:0] K_COLONCOLON = 5'd9;
  localparam logic [KIND_W-1:0] K_STRING     = 5'd10;
  localparam logic [KIND_W-1:0] K_STAR       = 5'd11;
  localparam logic [KIND_W-1:0] K_SLASH      = 5'd12;
  localparam logic [KIND_W-1:0] K_SLASHSLASH = 5'd13;
  localparam logic [KIND_W-1:0] K_PIPE       = 5'd14;
  localparam logic [KIND_W-1:0] K_PLUS       = 5'd15;
  localparam logic [KIND_W-1:0] K_MIN        = 5'd16;
  localparam logic [KIND_W-1:0] K_EQ         = 5'd17;
  localparam logic [KIND_W-1:0] K_EQEQ       = 5'd18;
  localparam logic [KIND_W-1:0] K_NEQ        = 5'd19;
  localparam logic [KIND_W-1:0] K_LT         = 5'd20;
  localparam logic [KIND_W-1:0] K_LTEQ       = 5'd21;
  localparam logic [KIND_W-1:0] K_GT         = 5'd22;
  localparam logic [KIND_W-1:0] K_GTEQ       = 5'd23;
  localparam logic [KIND_W-1:0] K_DOLLAR     = 5'd24;
  localparam logic [KIND_W-1:0] K_LITERAL    = 5'd25;
  localparam logic [KIND_W-1:0] K_INT        = 5'd26;
  localparam logic [KIND_W-1:0] K_FLOAT      = 5'd27;
  localparam logic [KIND_W-1:0] K_EOF        = 5'd28;

  localparam logic ERR_NONE    = 1'b0;
  localparam logic ERR_BADCHAR = 1'b1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } xts_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [POS_W-1:0]  token_start;
    logic [LEN_W-1:0]  token_length;
    logic              error_code;
    logic              last_of_run;
  } xts_result_t;

  // results of one byte, packed to the front, count of valid ones
  typedef struct packed {
    logic [2:0]                 count;
    xts_result_t [RES_MAX-1:0]  res;
  } xts_burst_t;

endpackage

/* hdl/xts_scan_core.sv */
// ----------------------------------------------------------------------------
// xts_scan_core: scanner state and single-step token logic
// Applies one byte to the scanner state and produces up to four results.
// ----------------------------------------------------------------------------
module xts_scan_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  xts_pkg::xts_item_t  item,
  output xts_pkg::xts_burst_t burst
);

  localparam int POS_W = xts_pkg::POS_W;
  localparam int LEN_W = xts_pkg::LEN_W;
  localparam int NSLOT = xts_pkg::RES_MAX;

  typedef enum logic [3:0] {
    S_START, S_NUMERIC, S_FLOAT, S_FLOAT_EXP, S_NAME, S_DOT, S_COLON, S_TICK,
    S_QUOTE, S_SLASH, S_BANG, S_LT, S_GT, S_EQ, S_NEG
  } state_t;

  typedef struct packed {
    logic                         emit_v;
    logic [xts_pkg::KIND_W-1:0]   kind;
    logic                         err;
    logic                         load;
    state_t                       nstate;
    logic                         quote;
  } sb_t;

  state_t           state;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] lstart;
  logic [LEN_W-1:0] llen;

  state_t           st;
  logic [POS_W-1:0] ls;
  logic [LEN_W-1:0] ll;
  logic [POS_W-1:0] pn;
  logic             again;
  logic             pair_v;
  logic [7:0]       pair_c;
  logic [xts_pkg::KIND_W-1:0] pair_two;
  logic [xts_pkg::KIND_W-1:0] pair_one;
  sb_t              sb;
  logic [NSLOT-1:0] slot_v;
  xts_pkg::xts_result_t slot [NSLOT];
  logic [2:0]       k;
  logic [2:0]       km;
  logic [7:0]       c;

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13);
  endfunction

  function automatic logic is_punct(input logic [7:0] ch);
    return (ch >= 8'd33 && ch <= 8'd47) || (ch >= 8'd58 && ch <= 8'd64) ||
           (ch >= 8'd91 && ch <= 8'd96) || (ch >= 8'd123 && ch <= 8'd126);
  endfunction

  function automatic logic is_name_char(input logic [7:0] ch);
    return is_letter(ch) || is_digit(ch) || ch == "_" || ch == "-" || ch == ".";
  endfunction

  function automatic xts_pkg::xts_result_t mk(input logic [xts_pkg::KIND_W-1:0] kd,
                                              input logic [POS_W-1:0] st_p,
                                              input logic [LEN_W-1:0] len,
                                              input logic er);
    xts_pkg::xts_result_t r;
    r.token_kind   = kd;
    r.token_start  = st_p;
    r.token_length = len;
    r.error_code   = er;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  // what a byte does when it opens a token
  function automatic sb_t start_decode(input logic [7:0] ch);
    sb_t r;
    r = '0;
    r.nstate = S_START;
    if (is_space(ch)) begin
      r = r;
    end else if (is_digit(ch)) begin
      r.load = 1'b1; r.nstate = S_NUMERIC;
    end else if (is_letter(ch) || ch == "_") begin
      r.load = 1'b1; r.nstate = S_NAME;
    end else begin
      case (ch)
        "(": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_LPAR; end
        ")": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_RPAR; end
        "[": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_LBRAC; end
        "]": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_RBRAC; end
        "@": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_AT; end
        ",": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_COMMA; end
        "*": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_STAR; end
        "|": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_PIPE; end
        "+": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_PLUS; end
        "$": begin r.emit_v = 1'b1; r.kind = xts_pkg::K_DOLLAR; end
        ".": begin r.load = 1'b1; r.nstate = S_DOT; end
        ":": begin r.load = 1'b1; r.nstate = S_COLON; end
        "/": begin r.load = 1'b1; r.nstate = S_SLASH; end
        "-": begin r.load = 1'b1; r.nstate = S_NEG; end
        "=": begin r.load = 1'b1; r.nstate = S_EQ; end
        "!": begin r.load = 1'b1; r.nstate = S_BANG; end
        "<": begin r.load = 1'b1; r.nstate = S_LT; end
        ">": begin r.load = 1'b1; r.nstate = S_GT; end
        8'd39: begin r.load = 1'b1; r.nstate = S_TICK; r.quote = 1'b1; end
        8'd34: begin r.load = 1'b1; r.nstate = S_QUOTE; r.quote = 1'b1; end
        default: begin
          r.emit_v = 1'b1; r.kind = xts_pkg::K_LPAR; r.err = xts_pkg::ERR_BADCHAR;
        end
      endcase
    end
    return r;
  endfunction

  always_comb begin
    c      = item.char_code;
    pn     = (pos == POS_W'(xts_pkg::MAX_TEXT - 1)) ? '0 : pos + 1'b1;
    sb     = start_decode(c);
    st     = state;
    ls     = lstart;
    ll     = llen;
    again  = 1'b0;
    pair_v = 1'b0;
    pair_c = '0;
    pair_two = xts_pkg::K_LPAR;
    pair_one = xts_pkg::K_LPAR;
    slot_v = '0;
    for (int i = 0; i < NSLOT; i++) slot[i] = '0;

    case (state)
      S_START: begin
        if (sb.emit_v) begin
          slot_v[0] = 1'b1; slot[0] = mk(sb.kind, pos, LEN_W'(1), sb.err);
        end
        if (sb.err) begin st = S_START; ll = '0; end
        if (sb.load) begin
          st = sb.nstate; ls = sb.quote ? pn : pos; ll = sb.quote ? '0 : LEN_W'(1);
        end
      end
      S_NUMERIC, S_FLOAT: begin
        if (c == "." && state == S_NUMERIC) begin
          if (ll < LEN_W'(xts_pkg::MAX_TEXT)) ll = ll + 1'b1;
          st = S_FLOAT;
        end else if (is_space(c) || is_punct(c)) begin
          slot_v[0] = 1'b1;
          slot[0] = mk((state == S_NUMERIC) ? xts_pkg::K_INT : xts_pkg::K_FLOAT,
                       ls, ll, xts_pkg::ERR_NONE);
          st = S_START; ll = '0; again = 1'b1;
        end else if (is_digit(c)) begin
          if (ll < LEN_W'(xts_pkg::MAX_TEXT)) ll = ll + 1'b1;
        end else if (c == "e" || c == "E") begin
          if (ll < LEN_W'(xts_pkg::MAX_TEXT)) ll = ll + 1'b1;
          st = S_FLOAT_EXP;
        end else begin
          slot_v[0] = 1'b1; slot[0] = mk(xts_pkg::K_LPAR, pos, LEN_W'(1), xts_pkg::ERR_BADCHAR);
          st = S_START; ll = '0;
        end
      end
      S_FLOAT_EXP, S_NAME, S_NEG: begin
        if ((state == S_NAME) ? is_name_char(c) : is_digit(c)) begin
          if (ll < LEN_W'(xts_pkg::MAX_TEXT)) ll = ll + 1'b1;
          if (state == S_NEG) st = S_NUMERIC;
        end else begin
          slot_v[0] = 1'b1;
          slot[0] = mk((state == S_NAME) ? xts_pkg::K_LITERAL :
                       (state == S_NEG) ? xts_pkg::K_MIN : xts_pkg::K_FLOAT,
                       ls, ll, xts_pkg::ERR_NONE);
          st = S_START; ll = '0; again = 1'b1;
        end
      end
      S_DOT: begin
        if (is_digit(c)) begin
          if (ll < LEN_W'(xts_pkg::MAX_TEXT)) ll = ll + 1'b1;
          st = S_FLOAT;
        end else begin
          pair_v = 1'b1; pair_c = "."; pair_two = xts_pkg::K_DOTDOT; pair_one = xts_pkg::K_DOT;
        end
      end
      S_COLON: begin
        pair_v = 1'b1; pair_c = ":"; pair_two = xts_pkg::K_COLONCOLON;
        pair_one = xts_pkg::K_COLON;
      end
      S_SLASH: begin
        pair_v = 1'b1; pair_c = "/"; pair_two = xts_pkg::K_SLASHSLASH;
        pair_one = xts_pkg::K_SLASH;
      end
      S_LT: begin
        pair_v = 1'b1; pair_c = "="; pair_two = xts_pkg::K_LTEQ; pair_one = xts_pkg::K_LT;
      end
      S_GT: begin
        pair_v = 1'b1; pair_c = "="; pair_two = xts_pkg::K_GTEQ; pair_one = xts_pkg::K_GT;
      end
      S_EQ: begin
        pair_v = 1'b1; pair_c = "="; pair_two = xts_pkg::K_EQEQ; pair_one = xts_pkg::K_EQ;
      end
      S_TICK, S_QUOTE: begin
        if (c == ((state == S_TICK) ? 8'd39 : 8'd34)) begin
          slot_v[0] = 1'b1; slot[0] = mk(xts_pkg::K_STRING, ls, ll, xts_pkg::ERR_NONE);
          st = S_START; ll = '0;
        end else if (ll < LEN_W'(xts_pkg::MAX_TEXT)) begin
          ll = ll + 1'b1;
        end
      end
      S_BANG: begin
        if (c == "=") begin
          if (ll < LEN_W'(xts_pkg::MAX_TEXT)) ll = ll + 1'b1;
          slot_v[0] = 1'b1; slot[0] = mk(xts_pkg::K_NEQ, ls, ll, xts_pkg::ERR_NONE);
        end else begin
          slot_v[0] = 1'b1; slot[0] = mk(xts_pkg::K_LPAR, pos, LEN_W'(1), xts_pkg::ERR_BADCHAR);
        end
        st = S_START; ll = '0;
      end
      default: begin
        // unused code: behave as the start state
        st = S_START;
        if (sb.emit_v) begin
          slot_v[0] = 1'b1; slot[0] = mk(sb.kind, pos, LEN_W'(1), sb.err);
        end
        if (sb.err) begin st = S_START; ll = '0; end
        if (sb.load) begin
          st = sb.nstate; ls = sb.quote ? pn : pos; ll = sb.quote ? '0 : LEN_W'(1);
        end
      end
    endcase

    // one- or two-character operators
    if (pair_v) begin
      if (c == pair_c) begin
        if (ll < LEN_W'(xts_pkg::MAX_TEXT)) ll = ll + 1'b1;
        slot_v[0] = 1'b1; slot[0] = mk(pair_two, ls, ll, xts_pkg::ERR_NONE);
      end else begin
        slot_v[0] = 1'b1; slot[0] = mk(pair_one, ls, ll, xts_pkg::ERR_NONE);
        again = 1'b1;
      end
      st = S_START; ll = '0;
    end

    // byte that ended a token opens the next one
    if (again) begin
      if (sb.emit_v) begin
        slot_v[1] = 1'b1; slot[1] = mk(sb.kind, pos, LEN_W'(1), sb.err);
      end
      if (sb.err) begin st = S_START; ll = '0; end
      if (sb.load) begin
        st = sb.nstate; ls = sb.quote ? pn : pos; ll = sb.quote ? '0 : LEN_W'(1);
      end
    end

    // final byte: flush pending token, then end-of-input
    if (item.end_of_text) begin
      slot_v[2] = 1'b1;
      case (st)
        S_NUMERIC:            slot[2] = mk(xts_pkg::K_INT, ls, ll, xts_pkg::ERR_NONE);
        S_FLOAT, S_FLOAT_EXP: slot[2] = mk(xts_pkg::K_FLOAT, ls, ll, xts_pkg::ERR_NONE);
        S_NAME:               slot[2] = mk(xts_pkg::K_LITERAL, ls, ll, xts_pkg::ERR_NONE);
        S_DOT:                slot[2] = mk(xts_pkg::K_DOT, ls, ll, xts_pkg::ERR_NONE);
        S_COLON:              slot[2] = mk(xts_pkg::K_COLON, ls, ll, xts_pkg::ERR_NONE);
        S_SLASH:              slot[2] = mk(xts_pkg::K_SLASH, ls, ll, xts_pkg::ERR_NONE);
        S_LT:                 slot[2] = mk(xts_pkg::K_LT, ls, ll, xts_pkg::ERR_NONE);
        S_GT:                 slot[2] = mk(xts_pkg::K_GT, ls, ll, xts_pkg::ERR_NONE);
        S_EQ:                 slot[2] = mk(xts_pkg::K_EQ, ls, ll, xts_pkg::ERR_NONE);
        S_NEG:                slot[2] = mk(xts_pkg::K_MIN, ls, ll, xts_pkg::ERR_NONE);
        S_BANG, S_TICK, S_QUOTE:
          slot[2] = mk(xts_pkg::K_LPAR, pos, LEN_W'(1), xts_pkg::ERR_BADCHAR);
        default:              slot_v[2] = 1'b0;
      endcase
      slot_v[3] = 1'b1;
      slot[3]   = mk(xts_pkg::K_EOF, pn, '0, xts_pkg::ERR_NONE);
    end

    // pack valid results to the front, mark the final one
    burst.res = '0;
    k = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_v[i]) begin
        burst.res[k[1:0]] = slot[i];
        k = k + 1'b1;
      end
    end
    km = k - 1'b1;
    if (k != '0) burst.res[km[1:0]].last_of_run = 1'b1;
    burst.count = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_START;
      pos    <= '0;
      lstart <= '0;
      llen   <= '0;
    end else if (fire) begin
      if (item.end_of_text) begin
        state  <= S_START;
        pos    <= '0;
        lstart <= '0;
        llen   <= '0;
      end else begin
        state  <= st;
        pos    <= pn;
        lstart <= ls;
        llen   <= ll;
      end
    end
  end

endmodule

/* hdl/xts_result_queue.sv */
// ----------------------------------------------------------------------------
// xts_result_queue: result register queue
// Takes a burst of up to four results per cycle, delivers one per transfer.
// ----------------------------------------------------------------------------
module xts_result_queue #(
  parameter int DEPTH = xts_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  xts_pkg::xts_burst_t  burst,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xts_pkg::xts_result_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  xts_pkg::xts_result_t mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] wcount;
  logic             pop;

  assign wcount    = push ? CNT_W'(burst.count) : '0;
  assign out_valid = (count != '0);
  assign pop       = out_valid & ~out_stall;
  assign out_data  = mem[head];
  // room for a full burst regardless of this cycle's pop
  assign room      = (count <= CNT_W'(DEPTH - xts_pkg::RES_MAX));

  always_ff @(posedge clk) begin
    for (int i = 0; i < xts_pkg::RES_MAX; i++) begin
      if (CNT_W'(i) < wcount) mem[tail + PTR_W'(i)] <= burst.res[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_W'(wcount);
      if (pop) head <= head + 1'b1;
      count <= count + wcount - CNT_W'(pop);
    end
  end

endmodule

/* hdl/xpath_token_scanner_unit.sv */
// ----------------------------------------------------------------------------
// xpath_token_scanner_unit: byte-serial XPath tokenizer
// Input register, single-step scanner and result queue.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte of the expression per transfer, end_of_text set on the
//           final byte. in_stall is high while the input register is full and
//           the result queue lacks room for a worst-case burst.
//   out_* : one token per transfer: kind, start, length, error flag, and
//           last_of_run on the final result caused by a given byte.
//   A byte yields zero to four results (a token it closes, a token it opens,
//   a flushed token and end-of-input on the final byte).
//   Path: a byte is held in the input register, goes through the scanner
//   logic, and its results are registered in the queue before out_* shows them.
//   Throughput: one byte per cycle while results are drained at least as
//   fast as they are made; output drains one result per cycle while
//   out_stall is low. The queue depth (QUEUE_DEPTH, a power of two of
//   at least four) sets how much burst slack exists before input stalls.
//   Reset (rst, synchronous): scanner returns to the start state at position
//   zero, the input register and result queue are emptied.
//   Receiver stall: results wait in the queue; once fewer than four free
//   entries remain the input side stalls. End-of-input also clears the
//   scanner state so the next byte opens a fresh expression.
// ----------------------------------------------------------------------------
module xpath_token_scanner_unit #(
  parameter int QUEUE_DEPTH = xts_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  xts_pkg::xts_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output xts_pkg::xts_result_t out_data
);

  logic                in_full;
  xts_pkg::xts_item_t  item;
  logic                room;
  logic                fire;
  xts_pkg::xts_burst_t burst;

  // the held byte goes through the scanner once the queue can take a burst
  assign fire     = in_full & room;
  assign in_stall = in_full & ~room;

  // input register: payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) item <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= (in_valid & ~in_stall) | (in_full & ~fire);
    end
  end

  xts_scan_core u_core (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (item),
    .burst (burst)
  );

  xts_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .burst     (burst),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hdl/xts_checker.sv */
// ----------------------------------------------------------------------------
// xts_checker: port-level checks of the XPath token scanner
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module xts_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input xts_pkg::xts_result_t out_data
);

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind == xts_pkg::K_EOF |->
      out_data.last_of_run && out_data.token_length == '0 &&
      out_data.error_code == xts_pkg::ERR_NONE)
    else $error("malformed end-of-input result");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_code == xts_pkg::ERR_BADCHAR |->
      out_data.token_length == 13'd1 && out_data.token_kind == xts_pkg::K_LPAR)
    else $error("malformed error result");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

endmodule

bind xpath_token_scanner_unit xts_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
